// File: design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types of the modular exponentiation block: register
// map, datapath operation codes and the command / status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int WORD_BITS_DEF = 32;   // default operand width
  localparam int DATA_BITS     = 32;   // width of ports and registers
  localparam int ADDR_BITS     = 4;    // three 32-bit registers, byte addressed
  localparam int IDX_MAX_BITS  = 5;    // holds an exponent bit index up to 31

  localparam logic [1:0] REG_MODULUS     = 2'd0;
  localparam logic [1:0] REG_PUBLIC_EXP  = 2'd1;
  localparam logic [1:0] REG_PRIVATE_EXP = 2'd2;

  localparam logic OPC_ENCRYPT = 1'b0;
  localparam logic OPC_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,        // capture operands, start reduction of the base
    OP_SQUARE,      // product <= acc * acc
    OP_MULT,        // product <= acc * base
    OP_STEP,        // one restoring division step
    OP_STORE_BASE,  // base <= reduced product
    OP_STORE_ACC    // acc  <= reduced product
  } dp_op_t;

  typedef struct packed {
    dp_op_t                  op;
    logic [IDX_MAX_BITS-1:0] bit_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_base;
    logic zero_exp;
    logic mod_zero;
    logic exp_bit;
  } dp_status_t;

endpackage

// File: design/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer of the exponentiation: scans the exponent from the top bit down,
// issues square and multiply products and counts the division steps of each
// reduction.
// ----------------------------------------------------------------------------
module mexp_ctrl #(
  parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 out_free,
  input  mexp_pkg::dp_status_t status,
  output mexp_pkg::dp_cmd_t    cmd,
  output logic                 out_load,
  output logic                 busy
);

  localparam int STEPS    = 2 * WORD_BITS;
  localparam int CNT_BITS = $clog2(STEPS);
  localparam int IDX_BITS = $clog2(WORD_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RED_BASE,
    S_STORE_BASE,
    S_PROD,
    S_RED,
    S_STORE,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_BITS-1:0] step_cnt_r, step_cnt_nxt;
  logic [IDX_BITS-1:0] bit_idx_r, bit_idx_nxt;
  logic                mult_phase_r, mult_phase_nxt;
  logic                last_step;

  assign last_step = (step_cnt_r == CNT_BITS'(STEPS - 1));

  always_comb begin
    state_nxt      = state_r;
    step_cnt_nxt   = step_cnt_r;
    bit_idx_nxt    = bit_idx_r;
    mult_phase_nxt = mult_phase_r;
    cmd.op         = mexp_pkg::OP_NONE;
    cmd.bit_idx    = mexp_pkg::IDX_MAX_BITS'(bit_idx_r);
    out_load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = mexp_pkg::OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        step_cnt_nxt = '0;
        if (status.zero_base || status.zero_exp) begin
          state_nxt = S_DONE;
        end else if (status.mod_zero) begin
          state_nxt = S_STORE_BASE;
        end else begin
          state_nxt = S_RED_BASE;
        end
      end
      S_RED_BASE: begin
        cmd.op       = mexp_pkg::OP_STEP;
        step_cnt_nxt = step_cnt_r + 1'b1;
        if (last_step) state_nxt = S_STORE_BASE;
      end
      S_STORE_BASE: begin
        cmd.op         = mexp_pkg::OP_STORE_BASE;
        bit_idx_nxt    = IDX_BITS'(WORD_BITS - 1);
        mult_phase_nxt = 1'b0;
        state_nxt      = S_PROD;
      end
      S_PROD: begin
        cmd.op       = mult_phase_r ? mexp_pkg::OP_MULT : mexp_pkg::OP_SQUARE;
        step_cnt_nxt = '0;
        state_nxt    = status.mod_zero ? S_STORE : S_RED;
      end
      S_RED: begin
        cmd.op       = mexp_pkg::OP_STEP;
        step_cnt_nxt = step_cnt_r + 1'b1;
        if (last_step) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.op = mexp_pkg::OP_STORE_ACC;
        if (!mult_phase_r && status.exp_bit) begin
          mult_phase_nxt = 1'b1;
          state_nxt      = S_PROD;
        end else begin
          mult_phase_nxt = 1'b0;
          if (bit_idx_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            bit_idx_nxt = bit_idx_r - 1'b1;
            state_nxt   = S_PROD;
          end
        end
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_cnt_r   <= '0;
      bit_idx_r    <= '0;
      mult_phase_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_cnt_r   <= step_cnt_nxt;
      bit_idx_r    <= bit_idx_nxt;
      mult_phase_r <= mult_phase_nxt;
    end
  end

endmodule

// File: design/mexp_dp.sv
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: operand registers, one WORD_BITS x WORD_BITS multiplier and a
// restoring divider that reduces the double-width product one bit a cycle.
// ----------------------------------------------------------------------------
module mexp_dp #(
  parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  mexp_pkg::dp_cmd_t     cmd,
  input  logic [WORD_BITS-1:0]  ld_base,
  input  logic [WORD_BITS-1:0]  ld_mod,
  input  logic [WORD_BITS-1:0]  ld_exp,
  output mexp_pkg::dp_status_t  status,
  output logic [WORD_BITS-1:0]  result
);

  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int IDX_BITS  = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] mod_r, exp_r, base_r, acc_r, rem_r;
  logic [PROD_BITS-1:0] prod_r;
  logic                 zero_base_r, zero_exp_r, mod_zero_r;
  logic [WORD_BITS:0]   rem_sh, rem_diff;
  logic [WORD_BITS-1:0] reduced;

  assign rem_sh   = {rem_r, prod_r[PROD_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, mod_r};
  // a zero modulus means plain truncation to the word
  assign reduced  = mod_zero_r ? prod_r[WORD_BITS-1:0] : rem_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      mexp_pkg::OP_LOAD: begin
        mod_r       <= ld_mod;
        exp_r       <= ld_exp;
        prod_r      <= PROD_BITS'(ld_base);
        rem_r       <= '0;
        acc_r       <= (ld_mod == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
        zero_base_r <= (ld_base == '0);
        zero_exp_r  <= (ld_exp == '0);
        mod_zero_r  <= (ld_mod == '0);
      end
      mexp_pkg::OP_SQUARE: begin
        prod_r <= PROD_BITS'(acc_r) * PROD_BITS'(acc_r);
        rem_r  <= '0;
      end
      mexp_pkg::OP_MULT: begin
        prod_r <= PROD_BITS'(acc_r) * PROD_BITS'(base_r);
        rem_r  <= '0;
      end
      mexp_pkg::OP_STEP: begin
        prod_r <= prod_r << 1;
        rem_r  <= rem_diff[WORD_BITS] ? rem_sh[WORD_BITS-1:0] : rem_diff[WORD_BITS-1:0];
      end
      mexp_pkg::OP_STORE_BASE: base_r <= reduced;
      mexp_pkg::OP_STORE_ACC:  acc_r  <= reduced;
      default: ;
    endcase
  end

  assign status.zero_base = zero_base_r;
  assign status.zero_exp  = zero_exp_r;
  assign status.mod_zero  = mod_zero_r;
  assign status.exp_bit   = exp_r[cmd.bit_idx[IDX_BITS-1:0]];

  assign result = zero_base_r ? '0 : (zero_exp_r ? WORD_BITS'(1) : acc_r);

endmodule

// File: design/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Raises a base to the public (encrypt) or private (decrypt) exponent modulo
// the configured modulus, with an APB register port for the key.
// ----------------------------------------------------------------------------
// One item is in work at a time. Left-to-right square-and-multiply runs on a
// single multiplier and a restoring divider that retires one quotient bit per
// cycle. Every exponent bit costs a square, and each set bit also a multiply.
// A zero base or zero exponent skips the products; a zero modulus skips the
// divider. The result sits in an output register, so the next base is taken
// while it waits. Write the registers only while the block is idle.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [31:0]                    in_base_value,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_power_result,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mexp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mexp_pkg::DATA_BITS-1:0] pwdata,
  output logic [mexp_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);

  logic [mexp_pkg::DATA_BITS-1:0] mod_r, pub_exp_r, priv_exp_r;
  logic                           out_valid_r;
  logic [31:0]                    out_power_result_r;
  logic                           cfg_write, in_accept, out_free, out_load, busy;
  logic [1:0]                     reg_idx;
  logic [WORD_BITS-1:0]           ld_exp, result;
  mexp_pkg::dp_cmd_t              cmd;
  mexp_pkg::dp_status_t           status;

  // register port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r      <= mexp_pkg::DATA_BITS'(1);
      pub_exp_r  <= '0;
      priv_exp_r <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        mexp_pkg::REG_MODULUS:     mod_r      <= pwdata;
        mexp_pkg::REG_PUBLIC_EXP:  pub_exp_r  <= pwdata;
        mexp_pkg::REG_PRIVATE_EXP: priv_exp_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mexp_pkg::REG_MODULUS:     prdata = mod_r;
      mexp_pkg::REG_PUBLIC_EXP:  prdata = pub_exp_r;
      mexp_pkg::REG_PRIVATE_EXP: prdata = priv_exp_r;
      default:                   prdata = '0;
    endcase
  end

  // input side
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign ld_exp    = (in_opcode == mexp_pkg::OPC_DECRYPT) ? priv_exp_r[WORD_BITS-1:0]
                                                          : pub_exp_r[WORD_BITS-1:0];

  mexp_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd),
    .out_load (out_load),
    .busy     (busy)
  );

  mexp_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .ld_base (in_base_value[WORD_BITS-1:0]),
    .ld_mod  (mod_r[WORD_BITS-1:0]),
    .ld_exp  (ld_exp),
    .status  (status),
    .result  (result)
  );

  // output register: free when empty or its transfer completes this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_power_result_r <= 32'(result);
  end

  assign out_valid        = out_valid_r;
  assign out_power_result = out_power_result_r;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("block not busy after taking an item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (mod_r[WORD_BITS-1:0] > WORD_BITS'(1)))
      |-> (out_power_result_r < 32'(mod_r[WORD_BITS-1:0])))
    else $error("result not below modulus");

endmodule
